FILE: hdl/abump_pkg.sv
// ----------------------------------------------------------------------------
// abump_pkg
// Shared types and constants of the aligned bump allocator.
// ----------------------------------------------------------------------------
package abump_pkg;

    localparam int ADDR_W              = 32;
    localparam int OP_W                = 3;
    localparam int CNT_W               = 6;
    localparam int CFG_IDX_W           = 1;
    localparam int MAX_RESULTS         = 32;
    localparam int DEFAULT_MAX_ENTRIES = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 3'd0,
        OP_RESET      = 3'd1,
        OP_NEXT       = 3'd2,
        OP_ITER_RESET = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_REL,
        S_END,
        S_ALLOC,
        S_NEXT,
        S_LIST
    } state_t;

endpackage

FILE: hdl/abump_table.sv
// ----------------------------------------------------------------------------
// abump_table
// Address table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module abump_table #(
    parameter int DEPTH = abump_pkg::DEFAULT_MAX_ENTRIES,
    parameter int AW    = 5
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [abump_pkg::ADDR_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [abump_pkg::ADDR_W-1:0]  rd_data
);

    logic [abump_pkg::ADDR_W-1:0] mem [DEPTH];
    logic [abump_pkg::ADDR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/abump_ctrl.sv
// ----------------------------------------------------------------------------
// abump_ctrl
// Request sequencer: configuration registers, offset and iterator state,
// staged alignment arithmetic, table access and result registers.
// ----------------------------------------------------------------------------
module abump_ctrl #(
    parameter int MAX_ENTRIES = abump_pkg::DEFAULT_MAX_ENTRIES,
    parameter int AW          = 5,
    parameter int CW          = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [abump_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abump_pkg::ADDR_W-1:0]     cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [abump_pkg::OP_W-1:0]       op,
    input  logic [abump_pkg::ADDR_W-1:0]     req_size,
    input  logic [abump_pkg::ADDR_W-1:0]     req_align,
    input  logic [abump_pkg::CNT_W-1:0]      max_count,
    output logic                             strobe,
    output logic [abump_pkg::ADDR_W-1:0]     address,
    output logic                             ok,
    output logic [abump_pkg::CNT_W-1:0]      count,
    output logic                             last,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [abump_pkg::ADDR_W-1:0]     wr_data,
    output logic                             rd_en,
    output logic [AW-1:0]                    rd_addr,
    input  logic [abump_pkg::ADDR_W-1:0]     rd_data
);

    localparam int AWD = abump_pkg::ADDR_W;
    localparam int NW  = abump_pkg::CNT_W;

    abump_pkg::state_t state_reg, state_next;

    logic [AWD-1:0] base_reg;
    logic [AWD-1:0] region_reg;
    logic [AWD-1:0] used_offset_reg, used_offset_next;
    logic [CW-1:0]  entry_count_reg, entry_count_next;
    logic [CW-1:0]  iter_reg, iter_next;

    logic [AWD-1:0] cur_reg, cur_next;
    logic [AWD-1:0] mask_reg, mask_next;
    logic           align_nz_reg, align_nz_next;
    logic [AWD-1:0] size_reg, size_next;
    logic [AWD-1:0] end_reg, end_next;
    logic [NW-1:0]  list_n_reg, list_n_next;
    logic [NW-1:0]  list_idx_reg, list_idx_next;

    logic           strobe_reg, strobe_next;
    logic [AWD-1:0] address_reg, address_next;
    logic           ok_reg, ok_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           last_reg, last_next;

    logic [NW:0]    ec_ext;
    logic [NW:0]    mc_ext;
    logic [NW:0]    n_min;
    logic [NW-1:0]  n_clamped;
    logic           full;
    logic           list_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            region_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                abump_pkg::REG_BASE_ADDRESS: base_reg   <= cfg_data;
                abump_pkg::REG_REGION_SIZE:  region_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= abump_pkg::S_IDLE;
            used_offset_reg <= '0;
            entry_count_reg <= '0;
            iter_reg        <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_offset_reg <= used_offset_next;
            entry_count_reg <= entry_count_next;
            iter_reg        <= iter_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        mask_reg     <= mask_next;
        align_nz_reg <= align_nz_next;
        size_reg     <= size_next;
        end_reg      <= end_next;
        list_n_reg   <= list_n_next;
        list_idx_reg <= list_idx_next;
        address_reg  <= address_next;
        ok_reg       <= ok_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign ec_ext    = (NW + 1)'(entry_count_reg);
    assign mc_ext    = (NW + 1)'(max_count);
    assign n_min     = (ec_ext < mc_ext) ? ec_ext : mc_ext;
    assign n_clamped = (n_min > (NW + 1)'(abump_pkg::MAX_RESULTS))
                       ? NW'(abump_pkg::MAX_RESULTS) : n_min[NW-1:0];
    assign full      = (entry_count_reg >= CW'(MAX_ENTRIES));
    assign list_last = ((list_idx_reg + NW'(1)) == list_n_reg);

    always_comb
    begin
        state_next       = state_reg;
        used_offset_next = used_offset_reg;
        entry_count_next = entry_count_reg;
        iter_next        = iter_reg;
        cur_next         = cur_reg;
        mask_next        = mask_reg;
        align_nz_next    = align_nz_reg;
        size_next        = size_reg;
        end_next         = end_reg;
        list_n_next      = list_n_reg;
        list_idx_next    = list_idx_reg;
        strobe_next      = 1'b0;
        address_next     = address_reg;
        ok_next          = ok_reg;
        count_next       = count_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        wr_addr          = AW'(entry_count_reg);
        wr_data          = cur_reg;
        rd_en            = 1'b0;
        rd_addr          = AW'(iter_reg);

        unique case (state_reg)
            abump_pkg::S_IDLE:
            begin
                if (start)
                begin
                    strobe_next  = 1'b1;
                    address_next = '0;
                    ok_next      = 1'b0;
                    count_next   = '0;
                    last_next    = 1'b1;
                    unique case (op)
                        abump_pkg::OP_ALLOC:
                        begin
                            strobe_next   = 1'b0;
                            cur_next      = base_reg + used_offset_reg;
                            mask_next     = req_align - AWD'(1);
                            align_nz_next = (req_align != '0);
                            size_next     = req_size;
                            state_next    = abump_pkg::S_ALIGN;
                        end
                        abump_pkg::OP_RESET:
                        begin
                            used_offset_next = '0;
                            entry_count_next = '0;
                            iter_next        = '0;
                            ok_next          = 1'b1;
                        end
                        abump_pkg::OP_NEXT:
                        begin
                            if (iter_reg < entry_count_reg)
                            begin
                                strobe_next = 1'b0;
                                rd_en       = 1'b1;
                                rd_addr     = AW'(iter_reg);
                                state_next  = abump_pkg::S_NEXT;
                            end
                        end
                        abump_pkg::OP_ITER_RESET:
                        begin
                            iter_next = '0;
                            ok_next   = 1'b1;
                        end
                        abump_pkg::OP_LIST:
                        begin
                            if (n_clamped != '0)
                            begin
                                strobe_next   = 1'b0;
                                rd_en         = 1'b1;
                                rd_addr       = '0;
                                list_n_next   = n_clamped;
                                list_idx_next = '0;
                                state_next    = abump_pkg::S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            abump_pkg::S_ALIGN:
            begin
                if (align_nz_reg)
                begin
                    cur_next = (cur_reg + mask_reg) & ~mask_reg;
                end
                state_next = abump_pkg::S_REL;
            end
            abump_pkg::S_REL:
            begin
                end_next   = cur_reg - base_reg;
                state_next = abump_pkg::S_END;
            end
            abump_pkg::S_END:
            begin
                end_next   = end_reg + size_reg;
                state_next = abump_pkg::S_ALLOC;
            end
            abump_pkg::S_ALLOC:
            begin
                strobe_next = 1'b1;
                count_next  = '0;
                last_next   = 1'b1;
                if ((end_reg > region_reg) || full)
                begin
                    address_next = '0;
                    ok_next      = 1'b0;
                end
                else
                begin
                    wr_en            = 1'b1;
                    used_offset_next = end_reg;
                    entry_count_next = entry_count_reg + CW'(1);
                    address_next     = cur_reg;
                    ok_next          = 1'b1;
                end
                state_next = abump_pkg::S_IDLE;
            end
            abump_pkg::S_NEXT:
            begin
                strobe_next  = 1'b1;
                address_next = rd_data;
                ok_next      = 1'b1;
                count_next   = '0;
                last_next    = 1'b1;
                iter_next    = iter_reg + CW'(1);
                state_next   = abump_pkg::S_IDLE;
            end
            abump_pkg::S_LIST:
            begin
                strobe_next  = 1'b1;
                address_next = rd_data;
                ok_next      = 1'b1;
                count_next   = list_n_reg;
                last_next    = list_last;
                if (list_last)
                begin
                    state_next = abump_pkg::S_IDLE;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = AW'(list_idx_reg + NW'(1));
                    list_idx_next = list_idx_reg + NW'(1);
                end
            end
            default: state_next = abump_pkg::S_IDLE;
        endcase
    end

    assign busy    = (state_reg != abump_pkg::S_IDLE);
    assign strobe  = strobe_reg;
    assign address = address_reg;
    assign ok      = ok_reg;
    assign count   = count_reg;
    assign last    = last_reg;

    a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |=> strobe_reg)
        else $error("list stream broken before last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= entry_count_reg)
        else $error("iterator past recorded entries");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !ok_reg |-> address_reg == '0 && count_reg == '0)
        else $error("failed result carries data");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en && state_reg == abump_pkg::S_ALLOC)
        else $error("table write outside commit");

endmodule

FILE: hdl/aligned_bump_allocator.sv
// ----------------------------------------------------------------------------
// aligned_bump_allocator
// Linear bump allocator with aligned requests and an address table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each result shows on
// the output ports for one cycle with strobe high and cannot be held off.
// Reset, iter_reset, unknown ops, a next with no entry left and an empty list
// complete without leaving idle (busy stays low). Next waits for the
// registered read of the address table. Alloc steps through the address
// chain (base plus offset, align, subtract base, add size, bound check and
// table write) with one adder per state. List streams one address per cycle
// from the table read port. Each result is registered and appears in the
// cycle after the cycle that produces it. The table needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module aligned_bump_allocator #(
    parameter int MAX_ENTRIES = abump_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [abump_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abump_pkg::ADDR_W-1:0]     cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [abump_pkg::OP_W-1:0]       op,
    input  logic [abump_pkg::ADDR_W-1:0]     req_size,
    input  logic [abump_pkg::ADDR_W-1:0]     req_align,
    input  logic [abump_pkg::CNT_W-1:0]      max_count,
    output logic                             strobe,
    output logic [abump_pkg::ADDR_W-1:0]     address,
    output logic                             ok,
    output logic [abump_pkg::CNT_W-1:0]      count,
    output logic                             last
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [abump_pkg::ADDR_W-1:0]  wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [abump_pkg::ADDR_W-1:0]  rd_data;

    abump_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .req_size  (req_size),
        .req_align (req_align),
        .max_count (max_count),
        .strobe    (strobe),
        .address   (address),
        .ok        (ok),
        .count     (count),
        .last      (last),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    abump_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
